// File: rtl/wsa_pkg.sv
// wsa_pkg: types, constants and the arctangent table of the waypoint steering block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsa_pkg;

    // working widths
    localparam int DW = 33;  // position offsets
    localparam int CW = 36;  // cordic x and y
    localparam int ZW = 17;  // cordic angle accumulator
    localparam int SW = 18;  // steering difference

    // angles in q3.13 radians
    localparam logic signed [ZW-1:0] ANG_PI      = 17'sd25736;
    localparam logic signed [ZW-1:0] ANG_NEG_PI  = -17'sd25736;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 17'sd12868;
    localparam logic signed [ZW-1:0] ANG_ZERO    = 17'sd0;

    // configuration register indexes and reset values
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_MIN_DISTANCE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MAX_STEER    = 2'd1;
    localparam int CFG_DW = 31;
    localparam logic [30:0] MIN_DISTANCE_RST = 31'd19661;
    localparam logic [14:0] MAX_STEER_RST    = 15'd4915;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] car_x;
        logic signed [31:0] car_y;
        logic signed [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic               steer_ok;
        logic signed [15:0] steer_angle;
    } steer_t;

    // rotating vector and its angle
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    // what travels alongside the vector
    typedef struct packed {
        logic               hold;     // bearing already settled, angle frozen
        logic               near;     // target too close
        logic signed [15:0] heading;
    } side_t;

    // atan(2^-i) in q3.13
    function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 17'sd6434;
            1:       r = 17'sd3798;
            2:       r = 17'sd2007;
            3:       r = 17'sd1019;
            4:       r = 17'sd511;
            5:       r = 17'sd256;
            6:       r = 17'sd128;
            7:       r = 17'sd64;
            8:       r = 17'sd32;
            9:       r = 17'sd16;
            10:      r = 17'sd8;
            11:      r = 17'sd4;
            12:      r = 17'sd2;
            13:      r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/wsa_front.sv
// wsa_front: offsets, distance test and quarter-turn set-up ahead of the cordic chain
// depends on wsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsa_front
    import wsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        take,
    input  wire pose_t       pose,
    input  wire logic [30:0] min_distance,
    output logic             out_valid,
    output vec_t             out_vec,
    output side_t            out_side
);

    // stage a: offsets
    logic                 a_valid_reg;
    logic signed [DW-1:0] a_dx_reg;
    logic signed [DW-1:0] a_dy_reg;
    logic signed [15:0]   a_hd_reg;

    // stage b: squares and start vector
    logic                 b_valid_reg;
    logic [61:0]          b_sqx_reg;
    logic [61:0]          b_sqy_reg;
    logic                 b_far_reg;
    vec_t                 b_vec_reg;
    side_t                b_side_reg;

    // stage c: compare
    logic                 c_valid_reg;
    vec_t                 c_vec_reg;
    side_t                c_side_reg;

    logic [61:0]          m2_reg;

    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic                 far_next;
    logic signed [CW-1:0] xv;
    logic signed [CW-1:0] yv;
    vec_t                 vec_next;
    logic                 hold_next;
    logic [62:0]          d2;
    logic                 near_next;

    always_ff @(posedge clk)
    begin
        m2_reg <= min_distance * min_distance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= take;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // magnitudes, an offset of 2^31 or more always clears the distance test
    assign adx      = a_dx_reg[DW-1] ? DW'(-a_dx_reg) : DW'(a_dx_reg);
    assign ady      = a_dy_reg[DW-1] ? DW'(-a_dy_reg) : DW'(a_dy_reg);
    assign far_next = adx[32] | adx[31] | ady[32] | ady[31];

    // bearing is atan2(-dx, dy): x = dy, y = -dx
    assign xv = CW'(a_dy_reg);
    assign yv = -CW'(a_dx_reg);

    always_comb
    begin
        vec_next  = '{x: xv, y: yv, z: ANG_ZERO};
        hold_next = 1'b0;
        if (xv == '0 && yv == '0)
        begin
            hold_next = 1'b1;
        end
        else if (yv == '0 && xv < 0)
        begin
            // straight behind
            hold_next   = 1'b1;
            vec_next.z  = ANG_PI;
        end
        else if (xv < 0)
        begin
            if (yv > 0)
            begin
                vec_next = '{x: yv, y: -xv, z: ANG_HALF_PI};
            end
            else
            begin
                vec_next = '{x: -yv, y: xv, z: -ANG_HALF_PI};
            end
        end
    end

    assign d2        = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
    assign near_next = !b_far_reg && (d2 < {1'b0, m2_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg   <= DW'(pose.target_x) - DW'(pose.car_x);
            a_dy_reg   <= DW'(pose.target_y) - DW'(pose.car_y);
            a_hd_reg   <= pose.heading;

            b_sqx_reg  <= adx[30:0] * adx[30:0];
            b_sqy_reg  <= ady[30:0] * ady[30:0];
            b_far_reg  <= far_next;
            b_vec_reg  <= vec_next;
            b_side_reg <= '{hold: hold_next, near: 1'b0, heading: a_hd_reg};

            c_vec_reg  <= b_vec_reg;
            c_side_reg <= '{hold: b_side_reg.hold, near: near_next,
                            heading: b_side_reg.heading};
        end
    end

    assign out_valid = c_valid_reg;
    assign out_vec   = c_vec_reg;
    assign out_side  = c_side_reg;

endmodule

`default_nettype wire

// File: rtl/wsa_cell.sv
// wsa_cell: one vectoring step of the cordic chain, registered
// depends on wsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsa_cell
    import wsa_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  in_valid,
    input  wire vec_t  in_vec,
    input  wire side_t in_side,
    output logic       out_valid,
    output vec_t       out_vec,
    output side_t      out_side
);

    logic  valid_reg;
    vec_t  vec_reg;
    side_t side_reg;
    vec_t  vec_next;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = in_vec.x >>> SHIFT;
    assign ys = in_vec.y >>> SHIFT;

    always_comb
    begin
        if (in_side.hold)
        begin
            vec_next = in_vec;
        end
        else if (in_vec.y >= 0)
        begin
            vec_next = '{x: in_vec.x + ys, y: in_vec.y - xs, z: in_vec.z + atan_val(SHIFT)};
        end
        else
        begin
            vec_next = '{x: in_vec.x - ys, y: in_vec.y + xs, z: in_vec.z - atan_val(SHIFT)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: rtl/wsa_back.sv
// wsa_back: clamps the bearing, subtracts the heading and applies the steering limit
// depends on wsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsa_back
    import wsa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic signed [ZW-1:0] in_z,
    input  wire side_t                in_side,
    input  wire logic [14:0]          max_steer,
    output logic                      out_valid,
    output steer_t                    out_data
);

    logic                 valid_reg;
    steer_t               data_reg;
    logic signed [ZW-1:0] zc;
    logic signed [SW-1:0] steer;
    logic [SW-1:0]        mag;
    logic                 ok;

    always_comb
    begin
        zc = in_z;
        if (in_z > ANG_PI)
        begin
            zc = ANG_PI;
        end
        else if (in_z < ANG_NEG_PI)
        begin
            zc = ANG_NEG_PI;
        end
    end

    assign steer = SW'(zc) - SW'(in_side.heading);
    assign mag   = steer[SW-1] ? SW'(-steer) : SW'(steer);
    assign ok    = !in_side.near && (mag <= SW'(max_steer));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg.steer_ok    <= ok;
            data_reg.steer_angle <= ok ? steer[15:0] : 16'sd0;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/waypoint_steering_angle_top.sv
// waypoint_steering_angle_top: steering angle toward a waypoint from the car pose
// depends on wsa_pkg, wsa_front, wsa_cell, wsa_back
//
//  channel | signals                               | direction | beat when
//  --------+---------------------------------------+-----------+---------------------------
//  pose    | pose_valid pose_stall pose_data       | in        | pose_valid & !pose_stall
//  steer   | steer_valid steer_stall steer_data    | out       | steer_valid & !steer_stall
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data| in        | cfg_valid & cfg_ready
//
// one pose beat per cycle while pose_stall is low; a result passes, in order, through
// three front stages, one cell per cordic step, the limit stage and the output register
// (the first front stage loads at the pose beat edge itself)
// the whole pipe moves together; only a full skid entry holds it, so pose_stall is a register
// reset clears valid bits and loads min_distance = 0.3 m and max_steer = 0.6 rad
// cfg_ready is always high; unused register indexes are ignored
`timescale 1ns / 1ps
`default_nettype none

module waypoint_steering_angle_top
    import wsa_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pose_valid,
    output logic                   pose_stall,
    input  wire pose_t             pose_data,
    output logic                   steer_valid,
    input  wire logic              steer_stall,
    output steer_t                 steer_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    // configuration registers
    logic [30:0] min_distance_reg;
    logic [14:0] max_steer_reg;

    // output register and skid entry
    logic   out_valid_reg;
    steer_t out_reg;
    logic   skid_full_reg;
    steer_t skid_reg;

    // pipe advances unless the skid entry is occupied
    logic adv;
    logic take;

    logic  chain_valid [CORDIC_STEPS+1];
    vec_t  chain_vec   [CORDIC_STEPS+1];
    side_t chain_side  [CORDIC_STEPS+1];

    logic   back_valid;
    steer_t back_data;

    assign adv        = !skid_full_reg;
    assign pose_stall = skid_full_reg;
    assign take       = pose_valid && adv;
    assign cfg_ready  = 1'b1;

    // user must do register writes only while the pipe is empty; not enforced by the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= MIN_DISTANCE_RST;
            max_steer_reg    <= MAX_STEER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_DISTANCE: min_distance_reg <= cfg_data[30:0];
                REG_MAX_STEER:    max_steer_reg    <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // offsets, distance test and the start vector
    wsa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .take         (take),
        .pose         (pose_data),
        .min_distance (min_distance_reg),
        .out_valid    (chain_valid[0]),
        .out_vec      (chain_vec[0]),
        .out_side     (chain_side[0])
    );

    // one cell per cordic step, each with its own fixed shift
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        wsa_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // clamp, heading subtraction and steering limit
    wsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_z      (chain_vec[CORDIC_STEPS].z),
        .in_side   (chain_side[CORDIC_STEPS]),
        .max_steer (max_steer_reg),
        .out_valid (back_valid),
        .out_data  (back_data)
    );

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            // skid drains into the output register once it is taken
            if (!steer_stall)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (back_valid)
        begin
            if (out_valid_reg && steer_stall)
            begin
                skid_full_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (!steer_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (!steer_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (back_valid)
        begin
            if (out_valid_reg && steer_stall)
            begin
                skid_reg <= back_data;
            end
            else
            begin
                out_reg <= back_data;
            end
        end
    end

    assign steer_valid = out_valid_reg;
    assign steer_data  = out_reg;

endmodule

`default_nettype wire

// File: rtl/wsa_checker.sv
// wsa_checker: port-level checks on the waypoint steering block, bound to its top level
// depends on wsa_pkg and waypoint_steering_angle_top
`timescale 1ns / 1ps
`default_nettype none

module wsa_checker
    import wsa_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pose_valid,
    input wire logic              pose_stall,
    input wire pose_t             pose_data,
    input wire logic              steer_valid,
    input wire logic              steer_stall,
    input wire steer_t            steer_data,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic [CFG_IW-1:0] cfg_index,
    input wire logic [CFG_DW-1:0] cfg_data
);

    // a stalled result beat holds
    a_steer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid && steer_stall |=> steer_valid && $stable(steer_data))
        else $error("steer beat changed while stalled");

    // a rejected result carries a zero angle
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        steer_valid && !steer_data.steer_ok |-> steer_data.steer_angle == 16'sd0)
        else $error("rejected steer beat with non-zero angle");

    // pose back-pressure only with a result waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pose_stall |-> steer_valid)
        else $error("pose stalled with empty output");

    // pose back-pressure starts only after the output was held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_stall) |-> $past(steer_valid && steer_stall))
        else $error("pose stall without output stall");

    // configuration port never pushes back
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write refused");

endmodule

bind waypoint_steering_angle_top wsa_checker u_wsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pose_valid  (pose_valid),
    .pose_stall  (pose_stall),
    .pose_data   (pose_data),
    .steer_valid (steer_valid),
    .steer_stall (steer_stall),
    .steer_data  (steer_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

`default_nettype wire

// File: test/wsa_steer_checker.sv
// wsa_steer_checker: watches the pose, steer and register channels, predicts every steering result
// depends on wsa_pkg for the beat structs, register indexes, reset values and angle constants
`timescale 1ns / 1ps

module wsa_steer_checker
    import wsa_pkg::*;
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pose_valid,
    input  logic              pose_stall,
    input  pose_t             pose_data,
    input  logic              steer_valid,
    input  logic              steer_stall,
    input  steer_t            steer_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output int                miscompares,
    output int                steer_owed,
    output int                steer_seen,
    output int                steer_passed
);

    localparam int NSTEP = (CORDIC_STEPS > 16) ? 16 : CORDIC_STEPS;
    localparam longint ATAN_Q13 [16] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                         32, 16, 8, 4, 2, 1, 0, 0};

    logic [30:0] min_dist_q16;
    logic [14:0] max_steer_q13;
    steer_t      steer_due [$];
    int          bad_beats;
    int          beats_in;
    int          beats_ok;

    // vectoring cordic, atan2(yv, xv) in q3.13, clamped to +-pi
    function automatic longint cordic_bearing(input longint xv, input longint yv);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        x = xv;
        y = yv;
        z = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (yv == 0 && xv < 0)
            return longint'(ANG_PI);
        if (xv < 0)
        begin
            if (yv > 0)
            begin
                x = yv;
                y = -xv;
                z = longint'(ANG_HALF_PI);
            end
            else
            begin
                x = -yv;
                y = xv;
                z = -longint'(ANG_HALF_PI);
            end
        end
        for (int i = 0; i < NSTEP; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_Q13[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_Q13[i];
            end
            x = nx;
            y = ny;
        end
        if (z > longint'(ANG_PI))
            z = longint'(ANG_PI);
        if (z < -longint'(ANG_PI))
            z = -longint'(ANG_PI);
        return z;
    endfunction

    // expected steering beat for one pose under the given limits
    function automatic steer_t steer_for_pose(input pose_t p, input logic [30:0] md,
                                              input logic [14:0] ms);
        steer_t res;
        longint dx;
        longint dy;
        longint lim;
        longint st;
        longint mag;
        res = '0;
        dx  = longint'($signed(p.target_x)) - longint'($signed(p.car_x));
        dy  = longint'($signed(p.target_y)) - longint'($signed(p.car_y));
        lim = longint'(1) <<< 31;
        if (dx < lim && dx > -lim && dy < lim && dy > -lim)
        begin
            if (dx * dx + dy * dy < longint'(md) * longint'(md))
                return res;
        end
        st  = cordic_bearing(dy, -dx) - longint'($signed(p.heading));
        mag = (st < 0) ? -st : st;
        if (mag > longint'(ms))
            return res;
        res.steer_ok    = 1'b1;
        res.steer_angle = st[15:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        steer_t want;
        if (!rst_n)
        begin
            min_dist_q16  <= MIN_DISTANCE_RST;
            max_steer_q13 <= MAX_STEER_RST;
            steer_due.delete();
            bad_beats      = 0;
            beats_in       = 0;
            beats_ok       = 0;
            miscompares   <= 0;
            steer_owed    <= 0;
            steer_seen    <= 0;
            steer_passed  <= 0;
        end
        else
        begin
            // prediction uses the limits in force before this edge
            if (pose_valid && !pose_stall)
                steer_due.insert(steer_due.size(),
                                 steer_for_pose(pose_data, min_dist_q16, max_steer_q13));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_DISTANCE: min_dist_q16  <= cfg_data[30:0];
                    REG_MAX_STEER:    max_steer_q13 <= cfg_data[14:0];
                    default:          ;
                endcase
            end
            if (steer_valid && !steer_stall)
            begin
                beats_in++;
                if (steer_data.steer_ok)
                    beats_ok++;
                if (steer_due.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: steer beat with none owed, got ok=%0b angle=%0d",
                                 $time, steer_data.steer_ok, steer_data.steer_angle);
                end
                else
                begin
                    want = steer_due.pop_front();
                    if (want.steer_ok !== steer_data.steer_ok ||
                        want.steer_angle !== steer_data.steer_angle)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("%0t: wrong beat, want ok=%0b angle=%0d, got ok=%0b angle=%0d",
                                     $time, want.steer_ok, want.steer_angle,
                                     steer_data.steer_ok, steer_data.steer_angle);
                    end
                end
            end
            miscompares  <= bad_beats;
            steer_owed   <= steer_due.size();
            steer_seen   <= beats_in;
            steer_passed <= beats_ok;
        end
    end

endmodule

// File: test/tb_top.sv
// tb_top: stimulus and verdict for waypoint_steering_angle_top
// depends on wsa_pkg, waypoint_steering_angle_top and wsa_steer_checker
`timescale 1ns / 1ps

module tb_top;
    import wsa_pkg::*;

    localparam int STEPS     = 14;
    localparam int PIPE_LAT  = STEPS + 5;   // pose beat to steer beat
    localparam int LONG_HOLD = 300;         // receiver hold-off, well past the pipe depth
    localparam int RAND_SETS = 8;           // random register settings after the directed part
    localparam int SET_BEATS = 78;          // pose beats per random setting

    // an index with no register behind it, must be ignored
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd2;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              pose_valid  = 1'b0;
    logic              pose_stall;
    pose_t             pose_data   = '0;
    logic              steer_valid;
    logic              steer_stall = 1'b0;
    steer_t            steer_data;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index   = '0;
    logic [CFG_DW-1:0] cfg_data    = '0;

    int miscompares;
    int steer_owed;
    int steer_seen;
    int steer_passed;

    // stimulus-side view of the limits, only used to aim headings near the boundary
    longint cur_min_dist = 19661;
    int     cur_max_steer = 4915;

    bit quiet;       // no idling on either side while set
    bit hold_req;    // asks the receiver for one long hold-off
    int poses_sent;
    int reg_writes;

    // 50 MHz
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    waypoint_steering_angle_top #(
        .CORDIC_STEPS (STEPS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pose_valid  (pose_valid),
        .pose_stall  (pose_stall),
        .pose_data   (pose_data),
        .steer_valid (steer_valid),
        .steer_stall (steer_stall),
        .steer_data  (steer_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    wsa_steer_checker #(
        .CORDIC_STEPS (STEPS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pose_valid   (pose_valid),
        .pose_stall   (pose_stall),
        .pose_data    (pose_data),
        .steer_valid  (steer_valid),
        .steer_stall  (steer_stall),
        .steer_data   (steer_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .miscompares  (miscompares),
        .steer_owed   (steer_owed),
        .steer_seen   (steer_seen),
        .steer_passed (steer_passed)
    );

    // ------------------------------------------------------------------
    // pose construction
    // ------------------------------------------------------------------

    function automatic pose_t pose_of(input logic [31:0] tx, input logic [31:0] ty,
                                      input logic [31:0] cx, input logic [31:0] cy,
                                      input logic [15:0] hd);
        pose_t p;
        p.target_x = tx;
        p.target_y = ty;
        p.car_x    = cx;
        p.car_y    = cy;
        p.heading  = hd;
        return p;
    endfunction

    // offset of random sign and random scale, from a few lsbs up to the full range
    function automatic longint rand_offset();
        longint v;
        v = longint'($signed($urandom)) >>> $urandom_range(0, 31);
        return v;
    endfunction

    // a well-formed pose: heading lands near the true bearing, straddling the steering limit
    function automatic pose_t aimed_pose(input longint dx, input longint dy);
        longint cx;
        longint cy;
        longint tx;
        longint ty;
        real    brg;
        int     spread;
        int     hd;
        cx     = longint'($signed($urandom)) >>> $urandom_range(1, 31);
        cy     = longint'($signed($urandom)) >>> $urandom_range(1, 31);
        tx     = cx + dx;   // may wrap, which just makes it a far or odd target
        ty     = cy + dy;
        brg    = $atan2(-real'(dx), real'(dy)) * 8192.0;
        spread = cur_max_steer + cur_max_steer / 4 + 16;
        hd     = $rtoi(brg) + $urandom_range(0, 2 * spread) - spread;
        if (hd > 32767)
            hd = 32767;
        if (hd < -32768)
            hd = -32768;
        return pose_of(tx[31:0], ty[31:0], cx[31:0], cy[31:0], hd[15:0]);
    endfunction

    // every field fully random, covers all bits of the payload
    function automatic pose_t noise_pose();
        logic [31:0] h;
        h = $urandom;
        return pose_of($urandom, $urandom, $urandom, $urandom, h[15:0]);
    endfunction

    // mostly aimed poses, some on the distance ring, some pure noise
    function automatic pose_t random_pose();
        int     pick;
        longint ring;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return noise_pose();
        if (pick < 35)
        begin
            // right on the minimum distance, a couple of lsbs either side
            ring = cur_min_dist + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1))
                ring = -ring;
            if ($urandom_range(0, 1))
                return aimed_pose(ring, longint'($urandom_range(0, 2)) - 1);
            return aimed_pose(longint'($urandom_range(0, 2)) - 1, ring);
        end
        return aimed_pose(rand_offset(), rand_offset());
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // one pose beat: random gap, then hold the payload until it is taken
    task automatic offer_pose(input pose_t p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            pose_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_data  <= p;
        pose_valid <= 1'b1;
        do
            @(posedge clk);
        while (pose_stall);
        poses_sent++;
    endtask

    // stop offering and wait until every owed steer beat has come back
    task automatic drain();
        pose_valid <= 1'b0;
        @(posedge clk);
        wait (steer_owed == 0);
        @(posedge clk);
    endtask

    // register write, only ever with the pipe empty
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        drain();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_MIN_DISTANCE: cur_min_dist  = longint'(val[30:0]);
            REG_MAX_STEER:    cur_max_steer = int'(val[14:0]);
            default:          ;
        endcase
    endtask

    // receiver: per beat a random stall, now and then one long hold-off
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                n        = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
                n = quiet ? 0 : $urandom_range(0, 14);
            if (n > 0)
            begin
                steer_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            steer_stall <= 1'b0;
            do
                @(posedge clk);
            while (!steer_valid);
        end
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------

    initial
    begin
        logic [31:0] r;
        longint      md;
        int          ms;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: 0.3 m and 0.6 rad
        offer_pose(pose_of(32'd0, 32'd0, 32'd0, 32'd0, 16'd0));               // same point, too close
        offer_pose(pose_of(32'd0, 32'd65536, 32'd0, 32'd0, 16'd0));           // dead ahead
        offer_pose(pose_of(32'd0, -32'sd65536, 32'd0, 32'd0, 16'sd25736));    // straight behind, facing it
        offer_pose(pose_of(32'd0, -32'sd65536, 32'd0, 32'd0, 16'd0));         // straight behind, too sharp
        offer_pose(pose_of(32'd65536, -32'sd65536, 32'd0, 32'd0, -16'sd19302)); // rear right quadrant
        offer_pose(pose_of(-32'sd65536, -32'sd65536, 32'd0, 32'd0, 16'sd19302)); // rear left quadrant
        offer_pose(pose_of(-32'sd65536, 32'd0, 32'd0, 32'd0, 16'sd12868));    // due left
        offer_pose(pose_of(32'd65536, 32'd0, 32'd0, 32'd0, -16'sd12868));     // due right
        offer_pose(pose_of(32'h7fffffff, 32'd0, 32'h80000000, 32'd0, 16'h8000)); // widest dx
        offer_pose(pose_of(32'h80000000, 32'd0, 32'h7fffffff, 32'd0, 16'h7fff)); // widest -dx
        offer_pose(pose_of(32'd0, 32'h7fffffff, 32'd0, 32'h80000000, 16'd0));    // widest dy
        offer_pose(pose_of(32'd0, 32'h80000000, 32'd0, 32'h7fffffff, 16'sd25736)); // widest -dy
        offer_pose(pose_of(32'd19661, 32'd0, 32'd0, 32'd0, -16'sd12868));     // exactly on the ring
        offer_pose(pose_of(32'd19660, 32'd0, 32'd0, 32'd0, -16'sd12868));     // one lsb inside
        offer_pose(pose_of(32'd0, 32'd19661, 32'd0, 32'd0, -16'sd4915));      // steer at the limit
        offer_pose(pose_of(32'd0, 32'd19661, 32'd0, 32'd0, -16'sd4916));      // one past the limit

        // widest limits: nothing too close, anything up to 4 rad allowed
        write_reg(REG_MIN_DISTANCE, 31'd0);
        write_reg(REG_MAX_STEER, 31'd32767);
        offer_pose(pose_of(32'd0, 32'd0, 32'd0, 32'd0, 16'd0));               // coincident points
        offer_pose(pose_of(32'h12345678, 32'hedcba987, 32'h12345678, 32'hedcba987, 16'h7fff));
        offer_pose(pose_of(32'd0, -32'sd100, 32'd0, 32'd0, 16'd0));           // behind, bearing pi
        offer_pose(pose_of(32'd0, -32'sd100, 32'd0, 32'd0, -16'sd7031));      // steer exactly at max
        offer_pose(pose_of(32'd0, -32'sd100, 32'd0, 32'd0, -16'sd7032));      // one past max
        offer_pose(pose_of(32'd0, -32'sd100, 32'd0, 32'd0, 16'h8000));

        // tightest limits: only far targets pass the ring, almost nothing passes steering
        write_reg(REG_MIN_DISTANCE, 31'h7fffffff);
        write_reg(REG_MAX_STEER, 31'd0);
        offer_pose(pose_of(32'h7fffffff, 32'd0, 32'd0, 32'd0, -16'sd12868));  // on the ring
        offer_pose(pose_of(32'h7ffffffe, 32'd0, 32'd0, 32'd0, -16'sd12868));  // just inside
        offer_pose(pose_of(32'h7fffffff, 32'd0, 32'hffffffff, 32'd0, -16'sd12868)); // far path

        // the unused index must leave both limits alone
        write_reg(REG_SPARE, 31'h5a5a5a5a);
        offer_pose(pose_of(32'h7fffffff, 32'd0, 32'd0, 32'd0, 16'd0));

        // random settings, each followed by a run of random poses
        for (int s = 0; s < RAND_SETS; s++)
        begin
            case ($urandom_range(0, 3))
                0:       md = longint'($urandom_range(0, 1 << 16));
                1:       md = longint'($urandom_range(0, 1 << 22));
                2:       md = longint'($urandom >> 1);
                default: md = longint'($urandom_range(0, 64));
            endcase
            ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(400, 32767);
            r  = $urandom;
            write_reg(REG_MIN_DISTANCE, md[30:0]);
            // junk in the upper data bits of the steering limit is ignored
            write_reg(REG_MAX_STEER, {r[15:0], ms[14:0]});

            quiet = (s == 2) || (s == 5);
            if (s == 3)
            begin
                // fill the pipe: receiver holds off while the sender keeps offering
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            for (int k = 0; k < SET_BEATS; k++)
            begin
                offer_pose(random_pose());
                // mid-phase pause until everything owed is back
                if (s == 6 && k == SET_BEATS / 2)
                    drain();
            end
            quiet = 1'b0;
        end

        drain();
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("covered %0d pose beats over %0d register writes, directed edges and random poses",
                 poses_sent, reg_writes);
        $display("%0d steering beats checked, %0d accepted and %0d rejected",
                 steer_seen, steer_passed, steer_seen - steer_passed);
        if (miscompares == 0 && steer_owed == 0)
            $display("waypoint_steering_angle_top: match");
        else
            $display("waypoint_steering_angle_top: mismatch");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("waypoint_steering_angle_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/wsa_pkg.sv
rtl/wsa_front.sv
rtl/wsa_cell.sv
rtl/wsa_back.sv
rtl/waypoint_steering_angle_top.sv
rtl/wsa_checker.sv
test/wsa_steer_checker.sv
test/tb_top.sv
